/* rtl/core/uwd_pkg.sv */
// shared types and codes of the usb port water detection controller
`timescale 1ns / 1ps

package uwd_pkg;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_OR_EDGE     = 3'd1,
    CMD_POLLING_SET = 3'd2,
    CMD_POLLING_RST = 3'd3,
    CMD_NEG_INVALID = 3'd4,
    CMD_BLANK       = 3'd5,
    CMD_UNBLANK     = 3'd6,
    CMD_RESTART     = 3'd7
  } cmd_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_DELAY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECHECK_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_FORCE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POLLING_UNSTOP = 3'd5;

  localparam logic [1:0] ROLE_NONE = 2'd0;
  localparam logic [1:0] ROLE_DUAL = 2'd1;
  localparam logic [1:0] ROLE_SINK = 2'd2;

  localparam logic [1:0] NOTIFY_NONE     = 2'd0;
  localparam logic [1:0] NOTIFY_STARTED  = 2'd1;
  localparam logic [1:0] NOTIFY_WATER_OR = 2'd2;
  localparam logic [1:0] NOTIFY_STOPPED  = 2'd3;

  localparam logic [1:0] WATER_NONE = 2'd0;
  localparam logic [1:0] WATER_OR   = 2'd1;
  localparam logic [1:0] WATER_AND  = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic       or_pin;
    logic       and_pin;
    logic       polling_request;
  } in_t;

  typedef struct packed {
    logic       sensor_enable;
    logic [1:0] role_request;
    logic [1:0] notify_code;
    logic [1:0] detect_state;
    logic [3:0] cable_checks;
    logic       polling_active;
  } out_t;

endpackage

/* rtl/core/usb_port_water_detect_controller.sv */
// top level of the usb port water detection controller
//
// in channel: one event request per accepted item (in_valid_i high, in_stall_o
// low at a rising edge), carrying the command and the sampled OR/AND pins.
// out channel: exactly one result per event, accepted when out_valid_o is high
// and out_stall_i is low. results come out in event order.
// the event is held in the input register; the updated state and result are
// written into the state and result registers once the result register is
// free. throughput: one event per cycle while out_stall_i stays low, set by
// the combinational state update between the input and the result register.
// when the receiver stalls, the result register holds and the input register
// keeps one more event; in_stall_o rises only when both are full.
// cfg channel: always ready, one register write per cycle, to be used only
// while no event is in flight.
// reset: delays 300/2000/7000 ticks, check limit 7, flags clear, polling
// stopped, no water, sensor enable high, all timers idle, both channels empty.
`timescale 1ns / 1ps

module usb_port_water_detect_controller #(
  parameter int unsigned TIMER_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  uwd_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output uwd_pkg::out_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [uwd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [uwd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import uwd_pkg::*;

  localparam logic [TIMER_WIDTH-1:0] TMax = '1;
  localparam logic [COUNT_WIDTH-1:0] CMax = '1;

  typedef struct packed {
    logic [15:0] connect_delay;
    logic [15:0] neg_delay;
    logic [15:0] recheck_delay;
    logic [3:0]  limit;
    logic        force_en;
    logic        unstop;
  } cfg_t;

  typedef struct packed {
    logic                   polling;
    logic [1:0]             water;
    logic [COUNT_WIDTH-1:0] count;
    logic                   blank;
    logic                   en;
    logic [TIMER_WIDTH-1:0] cc;
    logic [TIMER_WIDTH-1:0] nc;
    logic [TIMER_WIDTH-1:0] rc;
    logic [1:0]             role;
    logic [1:0]             notify;
  } st_t;

  function automatic logic [TIMER_WIDTH-1:0] load_value(input logic [15:0] d);
    if (d == 16'd0) begin
      return TIMER_WIDTH'(1);
    end
    if (32'(d) > 32'(TMax)) begin
      return TMax;
    end
    return TIMER_WIDTH'(d);
  endfunction

  function automatic logic below_limit(input logic [COUNT_WIDTH-1:0] cnt,
                                       input logic [3:0] lim);
    return 8'(cnt) < 8'(lim);
  endfunction

  function automatic st_t water_check(input st_t s, input cfg_t c,
                                      input logic por, input logic pand);
    st_t r;
    r = s;
    if (!r.polling || r.blank) begin
      return r;
    end
    r.role = ROLE_DUAL;
    r.en   = 1'b1;
    if (r.count == '0) begin
      if (!por) begin
        r.notify = NOTIFY_STARTED;
        r.water  = WATER_NONE;
      end
    end else if (below_limit(r.count, c.limit)) begin
      if (!por) begin
        if (r.cc == '0) begin
          r.cc = load_value(c.connect_delay);
        end
        r.en = 1'b0;
      end else if (pand) begin
        r.water = WATER_AND;
      end
    end
    return r;
  endfunction

  function automatic st_t restart_check(input st_t s, input cfg_t c,
                                        input logic por, input logic pand);
    st_t r;
    r = s;
    r.rc = '0;
    r.count = '0;
    return water_check(r, c, por, pand);
  endfunction

  function automatic st_t connect_check(input st_t s, input cfg_t c);
    st_t r;
    r = s;
    if (!r.polling) begin
      return r;
    end
    if (r.water == WATER_NONE) begin
      r.en = 1'b1;
      return r;
    end
    if (!c.unstop) begin
      r.role = ROLE_SINK;
    end
    if (r.water == WATER_OR) begin
      r.notify = NOTIFY_WATER_OR;
      if (r.count != CMax) begin
        r.count = r.count + COUNT_WIDTH'(1);
      end
      if (below_limit(r.count, c.limit) && !r.blank && r.rc == '0) begin
        r.rc = load_value(c.recheck_delay);
      end
    end else if (r.water == WATER_AND) begin
      r.notify = NOTIFY_STOPPED;
    end
    r.en = 1'b1;
    return r;
  endfunction

  function automatic st_t negotiation_check(input st_t s, input cfg_t c,
                                            input logic por, input logic pand);
    st_t r;
    r = s;
    if (r.polling) begin
      r.notify = NOTIFY_STARTED;
      r.en     = 1'b1;
    end else if (!c.force_en) begin
      return r;
    end
    return restart_check(r, c, por, pand);
  endfunction

  function automatic st_t polling_set(input st_t s, input cfg_t c, input logic req);
    st_t r;
    r = s;
    if (r.polling == req) begin
      return r;
    end
    r.polling = req;
    r.water   = WATER_NONE;
    r.rc      = '0;
    if (r.nc != '0) begin
      return r;
    end
    if (req) begin
      r.notify = NOTIFY_STARTED;
      r.en     = 1'b1;
    end else if (!c.force_en) begin
      r.count = '0;
      r.en    = 1'b0;
    end
    return r;
  endfunction

  cfg_t cfg_q;
  st_t  st_q, st_d;
  in_t  in_q;
  logic in_vld_q;
  logic out_vld_q;
  out_t out_q;
  logic adv;
  logic fc, fn, fr;

  assign adv         = ~out_vld_q | ~out_stall_i;
  assign in_stall_o  = in_vld_q & ~adv;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    st_d        = st_q;
    st_d.role   = ROLE_NONE;
    st_d.notify = NOTIFY_NONE;
    fc = 1'b0;
    fn = 1'b0;
    fr = 1'b0;
    case (cmd_e'(in_q.command))
      CMD_TICK: begin
        if (st_d.cc != '0) begin
          st_d.cc = st_d.cc - TIMER_WIDTH'(1);
          fc = (st_d.cc == '0);
        end
        if (st_d.nc != '0) begin
          st_d.nc = st_d.nc - TIMER_WIDTH'(1);
          fn = (st_d.nc == '0);
        end
        if (st_d.rc != '0) begin
          st_d.rc = st_d.rc - TIMER_WIDTH'(1);
          fr = (st_d.rc == '0);
        end
        if (fc) begin
          st_d = connect_check(st_d, cfg_q);
        end
        if (fn) begin
          st_d = negotiation_check(st_d, cfg_q, in_q.or_pin, in_q.and_pin);
        end
        if (fr) begin
          st_d = water_check(st_d, cfg_q, in_q.or_pin, in_q.and_pin);
        end
      end
      CMD_OR_EDGE: begin
        if (in_q.and_pin) begin
          st_d.water = WATER_AND;
        end else if (st_d.water != WATER_AND) begin
          st_d.water = WATER_OR;
        end
        if (!cfg_q.force_en) begin
          st_d.en = 1'b0;
        end
        st_d.cc = load_value(cfg_q.connect_delay);
      end
      CMD_POLLING_SET: begin
        st_d = polling_set(st_d, cfg_q, in_q.polling_request);
      end
      CMD_POLLING_RST: begin
        st_d.polling = 1'b1;
        st_d.water   = WATER_NONE;
        st_d.count   = '0;
        st_d.role    = ROLE_DUAL;
        st_d.notify  = NOTIFY_STARTED;
        st_d.en      = 1'b1;
      end
      CMD_NEG_INVALID: begin
        if (!cfg_q.force_en) begin
          st_d.en = 1'b0;
        end
        st_d.nc = load_value(cfg_q.neg_delay);
      end
      CMD_BLANK: begin
        st_d.blank = 1'b1;
        st_d.rc    = '0;
      end
      CMD_UNBLANK: begin
        st_d.blank = 1'b0;
        st_d.count = '0;
        if (st_d.water != WATER_NONE) begin
          st_d = water_check(st_d, cfg_q, in_q.or_pin, in_q.and_pin);
        end
      end
      CMD_RESTART: begin
        st_d = restart_check(st_d, cfg_q, in_q.or_pin, in_q.and_pin);
      end
      default: begin
        st_d = st_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.connect_delay <= 16'd300;
      cfg_q.neg_delay     <= 16'd2000;
      cfg_q.recheck_delay <= 16'd7000;
      cfg_q.limit         <= 4'd7;
      cfg_q.force_en      <= 1'b0;
      cfg_q.unstop        <= 1'b0;
      st_q.polling        <= 1'b0;
      st_q.water          <= WATER_NONE;
      st_q.count          <= '0;
      st_q.blank          <= 1'b0;
      st_q.en             <= 1'b1;
      st_q.cc             <= '0;
      st_q.nc             <= '0;
      st_q.rc             <= '0;
      st_q.role           <= ROLE_NONE;
      st_q.notify         <= NOTIFY_NONE;
      in_vld_q            <= 1'b0;
      out_vld_q           <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_CONNECT_DELAY:  cfg_q.connect_delay <= cfg_data_i;
          CFG_NEG_DELAY:      cfg_q.neg_delay     <= cfg_data_i;
          CFG_RECHECK_DELAY:  cfg_q.recheck_delay <= cfg_data_i;
          CFG_CHECK_LIMIT:    cfg_q.limit         <= cfg_data_i[3:0];
          CFG_ENABLE_FORCE:   cfg_q.force_en      <= cfg_data_i[0];
          CFG_POLLING_UNSTOP: cfg_q.unstop        <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
      if (adv && in_vld_q) begin
        st_q <= st_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (adv && in_vld_q) begin
      out_q.sensor_enable  <= st_d.en;
      out_q.role_request   <= st_d.role;
      out_q.notify_code    <= st_d.notify;
      out_q.detect_state   <= st_d.water;
      out_q.cable_checks   <= 4'(st_d.count);
      out_q.polling_active <= st_d.polling;
    end
  end

endmodule
